>>> hdl/sppr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppr_pkg
// Shared constants and types for the stepper pulse generator with a
// parabolic speed ramp.
// ----------------------------------------------------------------------------
package sppr_pkg;

  // Ramp shape
  localparam int unsigned RAMP_STEPS     = 1000;
  localparam int unsigned RAMP_DIVISIONS = 100;
  localparam int unsigned RAMP_IV        = RAMP_STEPS / RAMP_DIVISIONS;

  localparam longint unsigned RAMP_SQ      = longint'(RAMP_STEPS) * longint'(RAMP_STEPS);
  localparam longint unsigned RAMP_DIVISOR = 2 * RAMP_SQ;
  localparam int DVS_W = $clog2(RAMP_DIVISOR + 1);

  // Serial datapath sizes: d is 16 bits, base_delay 15 bits
  localparam int D_W   = 16;
  localparam int SQ_W  = 2 * D_W;
  localparam int BD_W  = 15;
  localparam int PR_W  = SQ_W + BD_W;
  localparam int NUM_W = PR_W + 2;
  localparam int CNT_W = $clog2(NUM_W);

  // Configuration register indexes
  localparam logic [1:0] REG_BASE_DELAY  = 2'd0;
  localparam logic [1:0] REG_PULSE_WIDTH = 2'd1;
  localparam logic [1:0] REG_DIR_X       = 2'd2;
  localparam logic [1:0] REG_DIR_Y       = 2'd3;

  localparam logic [BD_W-1:0] BASE_DELAY_RST  = 15'd90;
  localparam logic [7:0]      PULSE_WIDTH_RST = 8'd6;

  typedef enum logic [1:0] {
    PH_X_HIGH = 2'd0,
    PH_X_LOW  = 2'd1,
    PH_Y_HIGH = 2'd2,
    PH_Y_LOW  = 2'd3
  } phase_t;

endpackage

>>> hdl/sppr_ramp_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppr_ramp_calc
// Bit-serial ramp delay: base + round(base * d^2 / R^2), d = |R - progress|.
// Shift-add square, shift-add scale by base, restoring divide by 2*R^2.
// ----------------------------------------------------------------------------
module sppr_ramp_calc (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start_i,
  input  logic [sppr_pkg::BD_W-1:0]     base_i,
  input  logic [15:0]                   prog_i,
  output logic                          done_o,
  output logic [15:0]                   delay_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SQ,
    S_MUL,
    S_DIV
  } state_t;

  state_t                         state_r;
  logic [sppr_pkg::CNT_W-1:0]     cnt_r;
  logic [sppr_pkg::D_W-1:0]       mc_r;
  logic [sppr_pkg::BD_W-1:0]      base_r;
  logic [sppr_pkg::SQ_W-1:0]      sq_r;
  logic [sppr_pkg::PR_W-1:0]      prod_r;
  logic [sppr_pkg::NUM_W-1:0]     dvd_r;
  logic [sppr_pkg::DVS_W-1:0]     rem_r;
  logic                           done_r;
  logic [15:0]                    delay_r;

  logic [15:0]                    rs;
  logic [sppr_pkg::D_W-1:0]       d;
  logic [sppr_pkg::D_W:0]         sq_sum;
  logic [sppr_pkg::SQ_W-1:0]      sq_nxt;
  logic [sppr_pkg::BD_W:0]        mul_sum;
  logic [sppr_pkg::PR_W-1:0]      prod_nxt;
  logic [sppr_pkg::DVS_W:0]       rem_sh;
  logic                           q_bit;
  logic [sppr_pkg::NUM_W-1:0]     dvd_nxt;

  always_comb begin
    rs = 16'(sppr_pkg::RAMP_STEPS);
    d  = (prog_i > rs) ? (prog_i - rs) : (rs - prog_i);

    // square: accumulate into the upper half, shift right one bit a cycle
    sq_sum = {1'b0, sq_r[sppr_pkg::SQ_W-1:sppr_pkg::D_W]}
           + (sq_r[0] ? {1'b0, mc_r} : '0);
    sq_nxt = {sq_sum, sq_r[sppr_pkg::D_W-1:1]};

    // scale by base, one multiplier bit of the square a cycle
    mul_sum  = {1'b0, prod_r[sppr_pkg::PR_W-1:sppr_pkg::SQ_W]}
             + (prod_r[0] ? {1'b0, base_r} : '0);
    prod_nxt = {mul_sum, prod_r[sppr_pkg::SQ_W-1:1]};

    // restoring divide, quotient bits shift in at the bottom
    rem_sh  = {rem_r, dvd_r[sppr_pkg::NUM_W-1]};
    q_bit   = (rem_sh >= (sppr_pkg::DVS_W+1)'(sppr_pkg::RAMP_DIVISOR));
    dvd_nxt = {dvd_r[sppr_pkg::NUM_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          done_r <= 1'b0;
          if (start_i) begin
            mc_r    <= d;
            base_r  <= base_i;
            sq_r    <= {{sppr_pkg::D_W{1'b0}}, d};
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sq_r <= sq_nxt;
          if (cnt_r == sppr_pkg::CNT_W'(sppr_pkg::D_W - 1)) begin
            prod_r  <= {{sppr_pkg::BD_W{1'b0}}, sq_nxt};
            cnt_r   <= '0;
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r <= prod_nxt;
          if (cnt_r == sppr_pkg::CNT_W'(sppr_pkg::SQ_W - 1)) begin
            // numerator 2*base*d^2 + R^2 gives round-half-up on the divide
            dvd_r   <= {1'b0, prod_nxt, 1'b0} + sppr_pkg::NUM_W'(sppr_pkg::RAMP_SQ);
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          dvd_r  <= dvd_nxt;
          rem_r  <= q_bit ? sppr_pkg::DVS_W'(rem_sh - (sppr_pkg::DVS_W+1)'(sppr_pkg::RAMP_DIVISOR))
                          : rem_sh[sppr_pkg::DVS_W-1:0];
          if (cnt_r == sppr_pkg::CNT_W'(sppr_pkg::NUM_W - 1)) begin
            delay_r <= {1'b0, base_r} + dvd_nxt[15:0];
            done_r  <= 1'b1;
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o  = done_r;
  assign delay_o = delay_r;

endmodule

>>> hdl/stepper_pulse_parabolic_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_pulse_parabolic_ramp
// Two-axis step pulse generator with a parabolic speed ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one microsecond tick (in_tuser = 0) or a start
//   command (in_tuser = 1); in_tdata carries end_reached, limit_hit and
//   pause_request. Every input beat yields exactly one output beat with the
//   pin levels for that tick, the run flags, the pair count and the delay.
//   Configuration is a plain write port (cfg_we/cfg_idx/cfg_data); the user
//   must write it only while no beat is in flight, the block does not enforce it.
// Throughput:
//   An ordinary tick's output beat is registered and presented in the cycle
//   after it is accepted, and a new tick can be taken in that same cycle when
//   out_tready is high, so one beat per cycle. A tick that closes a pair on a
//   ramp update point runs the serial delay unit (square, scale, divide); its
//   output beat waits for that unit, with the input held off meanwhile.
// Reset:
//   Registers return to their defaults, no run active, no beat pending.
// Stall:
//   The output beat holds while out_tready is low; in_tready stays low
//   until the pending beat is taken.
// ----------------------------------------------------------------------------
module stepper_pulse_parabolic_ramp (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] end_reached, [1] limit_hit, [2] pause_request
  input  logic        in_tuser,   // [0] command

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [0] pulse_x, [1] pulse_y, [2] dir_x, [3] dir_y,
                                  // [4] busy_res, [5] stopped_by_limit,
                                  // [37:6] steps_done, [53:38] current_delay

  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [14:0] cfg_data
);

  // configuration
  logic [sppr_pkg::BD_W-1:0] base_r;
  logic [7:0]                pw_r;
  logic                      dir_x_r;
  logic                      dir_y_r;

  // run state
  sppr_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]      timer_r, timer_nxt;
  logic [31:0]      steps_r, steps_nxt;
  logic [15:0]      delay_r, delay_nxt;
  logic [15:0]      nus_r, nus_nxt;
  logic [15:0]      prog_r, prog_nxt;
  logic             running_r, running_nxt;
  logic             limit_r, limit_nxt;
  logic             px_r, px_nxt;
  logic             py_r, py_nxt;
  logic             out_valid_r;
  logic             busy_r;
  logic             upd;

  logic             accept;
  logic             start, endr, lim, pause;
  logic             boundary, hi_phase;
  logic [15:0]      len;
  logic [15:0]      tmr_inc;
  logic [31:0]      steps_inc;

  logic             calc_done;
  logic [15:0]      calc_delay;

  assign in_tready = !busy_r && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  assign start = in_tuser;
  assign endr  = in_tdata[0];
  assign lim   = in_tdata[1];
  assign pause = in_tdata[2];

  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    steps_nxt   = steps_r;
    delay_nxt   = delay_r;
    nus_nxt     = nus_r;
    prog_nxt    = prog_r;
    running_nxt = running_r;
    limit_nxt   = limit_r;
    px_nxt      = 1'b0;
    py_nxt      = 1'b0;
    upd         = 1'b0;

    boundary  = (phase_r == sppr_pkg::PH_X_HIGH) && (timer_r == 16'd0);
    hi_phase  = (phase_r == sppr_pkg::PH_X_HIGH) || (phase_r == sppr_pkg::PH_Y_HIGH);
    len       = hi_phase ? {8'd0, pw_r} : delay_r;
    if (len == 16'd0) begin
      len = 16'd1;
    end
    tmr_inc   = timer_r + 16'd1;
    steps_inc = (steps_r == 32'hFFFF_FFFF) ? steps_r : steps_r + 32'd1;

    if (start) begin
      running_nxt = 1'b1;
      limit_nxt   = 1'b0;
      steps_nxt   = '0;
      prog_nxt    = '0;
      delay_nxt   = {base_r, 1'b0};
      nus_nxt     = 16'(sppr_pkg::RAMP_IV - 1);
      phase_nxt   = sppr_pkg::PH_X_HIGH;
      timer_nxt   = '0;
    end else if (running_r) begin
      if (boundary && (endr || lim)) begin
        running_nxt = 1'b0;
        if (lim) begin
          limit_nxt = 1'b1;
        end
      end else if (pause) begin
        // a pin mid high phase stays high
        px_nxt = (phase_r == sppr_pkg::PH_X_HIGH) && (timer_r != 16'd0);
        py_nxt = (phase_r == sppr_pkg::PH_Y_HIGH) && (timer_r != 16'd0);
      end else begin
        px_nxt = (phase_r == sppr_pkg::PH_X_HIGH);
        py_nxt = (phase_r == sppr_pkg::PH_Y_HIGH);
        if (tmr_inc >= len) begin
          timer_nxt = '0;
          if (phase_r == sppr_pkg::PH_Y_LOW) begin
            phase_nxt = sppr_pkg::PH_X_HIGH;
            steps_nxt = steps_inc;
            if ((steps_inc == {16'd0, nus_r}) &&
                (steps_inc <= 32'(sppr_pkg::RAMP_STEPS))) begin
              nus_nxt  = nus_r + 16'(sppr_pkg::RAMP_IV);
              prog_nxt = prog_r + 16'(sppr_pkg::RAMP_IV);
              upd      = 1'b1;
            end
          end else begin
            phase_nxt = sppr_pkg::phase_t'(phase_r + 2'd1);
          end
        end else begin
          timer_nxt = tmr_inc;
        end
      end
    end
  end

  sppr_ramp_calc u_ramp (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (accept && upd),
    .base_i  (base_r),
    .prog_i  (prog_nxt),
    .done_o  (calc_done),
    .delay_o (calc_delay)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= sppr_pkg::BASE_DELAY_RST;
      pw_r    <= sppr_pkg::PULSE_WIDTH_RST;
      dir_x_r <= 1'b0;
      dir_y_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sppr_pkg::REG_BASE_DELAY:  base_r  <= cfg_data;
        sppr_pkg::REG_PULSE_WIDTH: pw_r    <= cfg_data[7:0];
        sppr_pkg::REG_DIR_X:       dir_x_r <= cfg_data[0];
        sppr_pkg::REG_DIR_Y:       dir_y_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sppr_pkg::PH_X_HIGH;
      timer_r     <= '0;
      steps_r     <= '0;
      delay_r     <= '0;
      nus_r       <= '0;
      prog_r      <= '0;
      running_r   <= 1'b0;
      limit_r     <= 1'b0;
      px_r        <= 1'b0;
      py_r        <= 1'b0;
      out_valid_r <= 1'b0;
      busy_r      <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      timer_r     <= timer_nxt;
      steps_r     <= steps_nxt;
      delay_r     <= delay_nxt;
      nus_r       <= nus_nxt;
      prog_r      <= prog_nxt;
      running_r   <= running_nxt;
      limit_r     <= limit_nxt;
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      // beat waits for the new delay when a ramp update is due
      out_valid_r <= !upd;
      busy_r      <= upd;
    end else if (busy_r) begin
      if (calc_done) begin
        delay_r     <= calc_delay;
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, delay_r, steps_r, limit_r, running_r,
                       dir_y_r, dir_x_r, py_r, px_r};

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-axis step pulse generator. A short table of
// directed beats covers idle ticks, start, pause, stops at and away from a
// pair boundary, restart, zero lengths and register extremes. Random phases
// with changing register settings and random source/sink idling follow. Each
// output beat is compared field by field with a directed row's own expected
// beat, or else an in-bench model of the pulse sequencer and its parabolic ramp.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_BEATS = 80;

  // Output beat, px at bit 0, laid out as out_tdata
  typedef struct packed {
    logic [15:0] dly;
    logic [31:0] steps;
    logic        lim;
    logic        busy;
    logic        dy;
    logic        dx;
    logic        py;
    logic        px;
  } beat_t;

  typedef struct packed {
    logic        is_reg;
    logic [1:0]  idx;
    logic [14:0] val;
    logic        cmd;
    logic        endr;
    logic        lim;
    logic        hold;
    logic        typed;
    beat_t       want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [14:0] cfg_data = '0;

  stepper_pulse_parabolic_ramp uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [0] end_reached, [1] limit_hit, [2] pause_request
    .in_tuser   (in_tuser),   // [0] command
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] px, [1] py, [2] dir_x, [3] dir_y, [4] busy,
                              // [5] limit, [37:6] steps, [53:38] delay
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow registers and sequencer state
  logic [14:0]      sh_base;
  logic [7:0]       sh_width;
  logic             sh_dirx;
  logic             sh_diry;
  sppr_pkg::phase_t sq_phase;
  logic [15:0]      sq_timer;
  logic [31:0]      sq_pairs;
  logic [15:0]      sq_delay;
  logic [31:0]      sq_next_upd;
  logic [15:0]      sq_progress;
  logic             sq_running;
  logic             sq_limit;

  beat_t pins_due[$];
  row_t  plan[$];
  int    mismatches = 0;
  int    src_idle_pct = 0;
  int    snk_stall_pct = 0;
  int    cyc = 0;

  function automatic logic [15:0] parabola_delay(logic [14:0] base, logic [15:0] prog);
    longint unsigned r, d, b, num, v;
    r = 64'(sppr_pkg::RAMP_STEPS);
    b = 64'(base);
    d = (prog > sppr_pkg::RAMP_STEPS) ? 64'(prog) - r : r - 64'(prog);
    num = 2 * b * d * d + r * r;
    v = b + num / (2 * r * r);
    return v[15:0];
  endfunction

  // Advance the sequencer by one beat and return the pins it drives
  function automatic beat_t step_pins(logic cmd, logic endr, logic lim, logic hold);
    beat_t o;
    int unsigned span;
    o = '0;
    if (cmd) begin
      sq_running  = 1'b1;
      sq_limit    = 1'b0;
      sq_pairs    = '0;
      sq_progress = '0;
      sq_delay    = 16'(2 * sh_base);
      sq_next_upd = sppr_pkg::RAMP_IV - 1;
      sq_phase    = sppr_pkg::PH_X_HIGH;
      sq_timer    = '0;
    end else if (sq_running) begin
      if (sq_phase == sppr_pkg::PH_X_HIGH && sq_timer == 0 && (endr || lim)) begin
        sq_running = 1'b0;
        if (lim) sq_limit = 1'b1;
      end else if (hold) begin
        // a pin mid high phase stays up, nothing advances
        if (sq_timer != 0) begin
          o.px = (sq_phase == sppr_pkg::PH_X_HIGH);
          o.py = (sq_phase == sppr_pkg::PH_Y_HIGH);
        end
      end else begin
        span = (sq_phase == sppr_pkg::PH_X_HIGH || sq_phase == sppr_pkg::PH_Y_HIGH)
             ? 32'(sh_width) : 32'(sq_delay);
        if (span == 0) span = 1;
        o.px = (sq_phase == sppr_pkg::PH_X_HIGH);
        o.py = (sq_phase == sppr_pkg::PH_Y_HIGH);
        sq_timer = sq_timer + 16'd1;
        if (sq_timer >= span) begin
          sq_timer = '0;
          if (sq_phase == sppr_pkg::PH_Y_LOW) begin
            sq_phase = sppr_pkg::PH_X_HIGH;
            if (sq_pairs != 32'hFFFF_FFFF) sq_pairs = sq_pairs + 1;
            if (sq_pairs == sq_next_upd && sq_pairs <= sppr_pkg::RAMP_STEPS) begin
              sq_next_upd = sq_next_upd + sppr_pkg::RAMP_IV;
              sq_progress = sq_progress + 16'(sppr_pkg::RAMP_IV);
              sq_delay    = parabola_delay(sh_base, sq_progress);
            end
          end else begin
            sq_phase = sppr_pkg::phase_t'(sq_phase + 2'd1);
          end
        end
      end
    end
    o.dx    = sh_dirx;
    o.dy    = sh_diry;
    o.busy  = sq_running;
    o.lim   = sq_limit;
    o.steps = sq_pairs;
    o.dly   = sq_delay;
    return o;
  endfunction

  function automatic beat_t pins(int unsigned px, int unsigned py, int unsigned dx,
                                 int unsigned dy, int unsigned busy, int unsigned lim,
                                 int unsigned steps, int unsigned dly);
    beat_t o;
    o.px = px[0]; o.py = py[0]; o.dx = dx[0]; o.dy = dy[0];
    o.busy = busy[0]; o.lim = lim[0]; o.steps = steps; o.dly = dly[15:0];
    return o;
  endfunction

  function automatic row_t beat_row(logic cmd, logic endr, logic lim, logic hold);
    row_t r;
    r = '0;
    r.cmd = cmd; r.endr = endr; r.lim = lim; r.hold = hold;
    return r;
  endfunction

  function automatic row_t typed_row(logic cmd, logic endr, logic lim, logic hold, beat_t w);
    row_t r;
    r = beat_row(cmd, endr, lim, hold);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic row_t reg_row(logic [1:0] idx, logic [14:0] val);
    row_t r;
    r = '0;
    r.is_reg = 1'b1; r.idx = idx; r.val = val;
    return r;
  endfunction

  function automatic int field_diff(string nm, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, nm, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic send_beat(logic cmd, logic endr, logic lim, logic hold,
                           logic typed, beat_t want);
    beat_t pred;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, hold, lim, endr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = step_pins(cmd, endr, lim, hold);
    pins_due.push_back(typed ? want : pred);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [14:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sppr_pkg::REG_BASE_DELAY:  sh_base  = val;
      sppr_pkg::REG_PULSE_WIDTH: sh_width = val[7:0];
      sppr_pkg::REG_DIR_X:       sh_dirx  = val[0];
      sppr_pkg::REG_DIR_Y:       sh_diry  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Output side: random stall and compare against the oldest prediction
  always @(posedge clk) begin : rx_check
    beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = beat_t'(out_tdata[53:0]);
      if (pins_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, out_tdata);
        mismatches += 1;
      end else begin
        want = pins_due.pop_front();
        mismatches += field_diff("pulse_x", 64'(want.px), 64'(got.px));
        mismatches += field_diff("pulse_y", 64'(want.py), 64'(got.py));
        mismatches += field_diff("dir_x", 64'(want.dx), 64'(got.dx));
        mismatches += field_diff("dir_y", 64'(want.dy), 64'(got.dy));
        mismatches += field_diff("busy", 64'(want.busy), 64'(got.busy));
        mismatches += field_diff("stopped_by_limit", 64'(want.lim), 64'(got.lim));
        mismatches += field_diff("steps_done", 64'(want.steps), 64'(got.steps));
        mismatches += field_diff("current_delay", 64'(want.dly), 64'(got.dly));
      end
    end
    out_tready <= (snk_stall_pct == 0) || ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats outstanding", $time, pins_due.size());
      $display("** stepper_pulse_parabolic_ramp: FAILED **");
      $finish;
    end
  end

  initial begin
    logic        cmd, endr, lim, hold;
    logic [14:0] base;
    logic [7:0]  width;
    int          n;
    bit          held;

    sh_base = sppr_pkg::BASE_DELAY_RST; sh_width = sppr_pkg::PULSE_WIDTH_RST;
    sh_dirx = 1'b0; sh_diry = 1'b0;
    sq_phase = sppr_pkg::PH_X_HIGH; sq_timer = '0; sq_pairs = '0; sq_delay = '0;
    sq_next_upd = '0; sq_progress = '0; sq_running = 1'b0; sq_limit = 1'b0;

    // idle ticks, start, pause and stop requests away from a boundary
    plan.push_back(typed_row(1'b0, 1'b0, 1'b0, 1'b0, pins(0, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b1, 1'b1, pins(0, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(typed_row(1'b1, 1'b0, 1'b0, 1'b0, pins(0, 0, 0, 0, 1, 0, 0, 180)));
    plan.push_back(typed_row(1'b0, 1'b0, 1'b0, 1'b0, pins(1, 0, 0, 0, 1, 0, 0, 180)));
    plan.push_back(typed_row(1'b0, 1'b0, 1'b0, 1'b1, pins(1, 0, 0, 0, 1, 0, 0, 180)));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b1, 1'b0, pins(1, 0, 0, 0, 1, 0, 0, 180)));
    // width shrinks under a running pulse
    plan.push_back(reg_row(sppr_pkg::REG_PULSE_WIDTH, 15'd1));
    plan.push_back(reg_row(sppr_pkg::REG_BASE_DELAY, 15'd1));
    plan.push_back(reg_row(sppr_pkg::REG_DIR_X, 15'd1));
    plan.push_back(reg_row(sppr_pkg::REG_DIR_Y, 15'd1));
    plan.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b0));
    // one full pair, pause at a low phase, then stop with both requests
    plan.push_back(typed_row(1'b1, 1'b0, 1'b0, 1'b0, pins(0, 0, 1, 1, 1, 0, 0, 2)));
    plan.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b1));
    repeat (5) plan.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b1, 1'b0, pins(0, 0, 1, 1, 0, 1, 1, 2)));
    // start wins over limit, then stop by end only
    plan.push_back(typed_row(1'b1, 1'b0, 1'b1, 1'b0, pins(0, 0, 1, 1, 1, 0, 0, 2)));
    plan.push_back(typed_row(1'b0, 1'b1, 1'b0, 1'b0, pins(0, 0, 1, 1, 0, 0, 0, 2)));
    // zero lengths and a restart mid-pair
    plan.push_back(reg_row(sppr_pkg::REG_BASE_DELAY, 15'd0));
    plan.push_back(reg_row(sppr_pkg::REG_PULSE_WIDTH, 15'd0));
    plan.push_back(typed_row(1'b1, 1'b0, 1'b0, 1'b0, pins(0, 0, 1, 1, 1, 0, 0, 0)));
    plan.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b0));
    plan.push_back(beat_row(1'b1, 1'b0, 1'b0, 1'b0));
    // register maxima, pause at a boundary, limit stop
    plan.push_back(reg_row(sppr_pkg::REG_BASE_DELAY, 15'd32767));
    plan.push_back(reg_row(sppr_pkg::REG_PULSE_WIDTH, 15'd255));
    plan.push_back(reg_row(sppr_pkg::REG_DIR_X, 15'd0));
    plan.push_back(typed_row(1'b1, 1'b0, 1'b0, 1'b0, pins(0, 0, 0, 1, 1, 0, 0, 65534)));
    plan.push_back(beat_row(1'b0, 1'b0, 1'b0, 1'b1));
    plan.push_back(typed_row(1'b0, 1'b0, 1'b1, 1'b0, pins(0, 0, 0, 1, 0, 1, 0, 65534)));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain;
        set_reg(plan[i].idx, plan[i].val);
      end else begin
        send_beat(plan[i].cmd, plan[i].endr, plan[i].lim, plan[i].hold,
                  plan[i].typed, plan[i].want);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain;
      case (p)
        0: begin base = 15'd1; width = 8'd1; end
        1: begin base = 15'($urandom_range(3)); width = 8'($urandom_range(2)); end
        2: begin base = 15'd2; width = 8'd1; end
        3: begin base = 15'd32767; width = 8'd255; end
        4: begin base = 15'($urandom_range(6, 1)); width = 8'($urandom_range(3, 1)); end
        default: begin base = 15'd1; width = 8'($urandom_range(2, 1)); end
      endcase
      set_reg(sppr_pkg::REG_BASE_DELAY, base);
      set_reg(sppr_pkg::REG_PULSE_WIDTH, {7'b0, width});
      set_reg(sppr_pkg::REG_DIR_X, 15'($urandom_range(1)));
      set_reg(sppr_pkg::REG_DIR_Y, 15'($urandom_range(1)));
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 61; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 61; end
        default: begin src_idle_pct = 31; snk_stall_pct = 31; end
      endcase

      n = 0;
      held = 1'b0;
      while (n < PHASE_BEATS) begin
        if ($urandom_range(9) == 0) begin
          // noise
          {cmd, endr, lim, hold} = 4'($urandom_range(15));
        end else begin
          cmd  = sq_running ? ($urandom_range(299) == 0) : ($urandom_range(3) == 0);
          endr = ($urandom_range(99) < 2);
          lim  = ($urandom_range(99) == 0);
          hold = ($urandom_range(9) == 0);
        end
        if (cmd || sq_running) n++;
        send_beat(cmd, endr, lim, hold, 1'b0, '0);
        if (p == 1 && n == PHASE_BEATS / 2 && !held) begin
          held = 1'b1;
          drain;
        end
      end
    end

    drain;
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("** stepper_pulse_parabolic_ramp: PASSED **");
    else
      $display("** stepper_pulse_parabolic_ramp: FAILED **");
    $finish;
  end

endmodule
